FILE: rtl/ipp_pkg.sv
// Shared types and codes for the identity payload parser.
package ipp_pkg;

  localparam int unsigned MinPayload = 5;
  localparam int unsigned PosLimit   = 255;

  typedef enum logic [2:0] {
    FK_SLOTS      = 3'd0,
    FK_VMAJOR     = 3'd1,
    FK_VMINOR     = 3'd2,
    FK_VENDOR_LEN = 3'd3,
    FK_VENDOR_CHR = 3'd4,
    FK_PROD_LEN   = 3'd5,
    FK_PROD_CHR   = 3'd6,
    FK_TRAIL      = 3'd7
  } field_kind_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_VENDOR_LONG  = 3'd2,
    ST_VENDOR_CUT   = 3'd3,
    ST_PROD_MISSING = 3'd4,
    ST_PROD_LONG    = 3'd5,
    ST_PROD_CUT     = 3'd6,
    ST_RSVD         = 3'd7
  } parse_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    field_kind_t   field_kind;
    logic [7:0]    field_value;
    logic [4:0]    char_index;
    logic          ends_payload;
    parse_status_t parse_status;
    logic          parse_ok;
  } result_t;

endpackage

FILE: rtl/ipp_in_stage.sv
// Input register stage: captures one beat and hands it to the parser core.
module ipp_in_stage
  import ipp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  output logic     out_valid,
  input  logic     out_ready,
  output in_beat_t out_beat
);

  logic     held_valid;
  in_beat_t held_beat;

  // Take a new beat whenever the held one is empty or moving on.
  assign in_ready  = !held_valid || out_ready;
  assign out_valid = held_valid;
  assign out_beat  = held_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_beat <= in_beat;
    end
  end

endmodule

FILE: rtl/ipp_core.sv
// Parser core: field tracking state, per-byte labeling and result register.
module ipp_core
  import ipp_pkg::*;
#(
  parameter int unsigned NAME_MAX = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  output logic     res_valid,
  input  logic     res_ready,
  output result_t  res
);

  // Encoding matches field_kind_t so a phase labels its byte directly.
  typedef enum logic [2:0] {
    PH_SLOTS      = 3'd0,
    PH_VMAJOR     = 3'd1,
    PH_VMINOR     = 3'd2,
    PH_VENDOR_LEN = 3'd3,
    PH_VENDOR_CHR = 3'd4,
    PH_PROD_LEN   = 3'd5,
    PH_PROD_CHR   = 3'd6,
    PH_TRAIL      = 3'd7
  } phase_t;

  localparam logic [7:0] NameMaxB   = 8'(NAME_MAX);
  localparam logic [7:0] MinPayB    = 8'(MinPayload);
  localparam logic [7:0] PosLimitB  = 8'(PosLimit);

  phase_t        phase, phase_next;
  logic [7:0]    byte_position, byte_position_next;
  logic [7:0]    name_length, name_length_next;
  logic [7:0]    name_counter, name_counter_next;
  parse_status_t first_error, first_error_next;
  result_t       res_next;
  logic          take;

  assign in_ready = !res_valid || res_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    name_length_next   = name_length;
    name_counter_next  = name_counter;
    first_error_next   = first_error;

    res_next              = '0;
    res_next.field_kind   = FK_TRAIL;
    res_next.field_value  = in_beat.data_byte;
    res_next.ends_payload = in_beat.final_byte;
    res_next.parse_status = ST_OK;

    if (byte_position != PosLimitB) begin
      res_next.field_kind = field_kind_t'(phase);
      unique case (phase)
        PH_SLOTS:  phase_next = PH_VMAJOR;
        PH_VMAJOR: phase_next = PH_VMINOR;
        PH_VMINOR: phase_next = PH_VENDOR_LEN;
        PH_VENDOR_LEN, PH_PROD_LEN: begin
          name_length_next  = in_beat.data_byte;
          name_counter_next = '0;
          if (in_beat.data_byte > NameMaxB) begin
            first_error_next = (phase == PH_VENDOR_LEN) ? ST_VENDOR_LONG : ST_PROD_LONG;
            phase_next       = PH_TRAIL;
          end else if (in_beat.data_byte == '0) begin
            phase_next = (phase == PH_VENDOR_LEN) ? PH_PROD_LEN : PH_TRAIL;
          end else begin
            phase_next = (phase == PH_VENDOR_LEN) ? PH_VENDOR_CHR : PH_PROD_CHR;
          end
        end
        PH_VENDOR_CHR, PH_PROD_CHR: begin
          res_next.char_index = name_counter[4:0];
          name_counter_next   = name_counter + 8'd1;
          if (name_counter_next >= name_length) begin
            phase_next = (phase == PH_VENDOR_CHR) ? PH_PROD_LEN : PH_TRAIL;
          end
        end
        default: phase_next = phase;
      endcase
      byte_position_next = byte_position + 8'd1;
    end

    if (in_beat.final_byte) begin
      priority if (byte_position_next < MinPayB) begin
        res_next.parse_status = ST_TOO_SHORT;
      end else if (first_error_next != ST_OK) begin
        res_next.parse_status = first_error_next;
      end else if (phase_next == PH_VENDOR_CHR) begin
        res_next.parse_status = ST_VENDOR_CUT;
      end else if (phase_next == PH_PROD_LEN) begin
        res_next.parse_status = ST_PROD_MISSING;
      end else if (phase_next == PH_PROD_CHR) begin
        res_next.parse_status = ST_PROD_CUT;
      end else begin
        res_next.parse_status = ST_OK;
      end
      res_next.parse_ok = (res_next.parse_status == ST_OK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SLOTS;
      byte_position <= '0;
      name_length   <= '0;
      name_counter  <= '0;
      first_error   <= ST_OK;
      res_valid     <= 1'b0;
    end else begin
      if (in_ready) begin
        res_valid <= in_valid;
      end
      if (take) begin
        res <= res_next;
        if (in_beat.final_byte) begin
          // Drop back to the start of a payload.
          phase         <= PH_SLOTS;
          byte_position <= '0;
          name_length   <= '0;
          name_counter  <= '0;
          first_error   <= ST_OK;
        end else begin
          phase         <= phase_next;
          byte_position <= byte_position_next;
          name_length   <= name_length_next;
          name_counter  <= name_counter_next;
          first_error   <= first_error_next;
        end
      end
    end
  end

endmodule

FILE: rtl/identity_payload_parser.sv
// Top level of the identity payload parser.
// Usage:
//   Payload bytes enter on the s_axis channel one beat at a time, in wire
//   order, with s_axis_tlast on the final byte of a payload. Every input beat
//   produces exactly one m_axis beat that labels the byte with the field it
//   fills (m_axis_tuser), repeats the byte, and gives the character index
//   for vendor and product name characters.
//   On the beat that carries m_axis_tlast, the status and ok flag in
//   m_axis_tdata report the outcome of the whole payload; on other beats
//   they read zero. Bytes past the 255th of a payload are labeled trailing.
// Pipeline and throughput:
//   Each accepted beat passes through the input register and then the
//   result register before it shows on m_axis. One beat is accepted per
//   cycle when the receiver keeps up; each byte needs only a phase step,
//   a length compare and a counter step.
// Reset and stalls:
//   rst (synchronous, active high) empties both registers and puts the
//   parser at the start of a payload; a final byte also returns the parser there.
//   When m_axis_tready is low the result register holds its beat, the
//   input register fills, and then s_axis_tready drops; nothing is lost.
module identity_payload_parser
  import ipp_pkg::*;
#(
  parameter int unsigned NAME_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] field_value, [12:8] char_index, [15:13] parse_status,
  // [16] parse_ok, [23:17] zero
  output logic [23:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] field_kind
  output logic        m_axis_tlast    // ends_payload
);

  in_beat_t in_beat, held_beat;
  logic     held_valid, core_ready;
  result_t  res;

  assign in_beat.data_byte  = s_axis_tdata;
  assign in_beat.final_byte = s_axis_tlast;

  ipp_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_beat   (in_beat),
    .out_valid (held_valid),
    .out_ready (core_ready),
    .out_beat  (held_beat)
  );

  ipp_core #(
    .NAME_MAX (NAME_MAX)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (held_valid),
    .in_ready  (core_ready),
    .in_beat   (held_beat),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {7'd0, res.parse_ok, res.parse_status, res.char_index,
                         res.field_value};
  assign m_axis_tuser = res.field_kind;
  assign m_axis_tlast = res.ends_payload;

endmodule

FILE: rtl/ipp_checker.sv
// Port-level checks for the identity payload parser, bound to the top level.
module ipp_checker
  import ipp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // Status and ok flag only report on the final byte.
  a_status_final: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[16:13] == 4'd0)
    else $error("status reported before final byte");

  // On the final byte ok is set exactly when the status is ok.
  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[16] == (m_axis_tdata[15:13] == ST_OK))
    else $error("ok flag disagrees with status");

  // A character index only accompanies name characters.
  a_index_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != FK_VENDOR_CHR && m_axis_tuser != FK_PROD_CHR
      |-> m_axis_tdata[12:8] == 5'd0)
    else $error("character index on a non-character byte");

endmodule

bind identity_payload_parser ipp_checker u_ipp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: sim/identity_payload_parser_tb.sv
// Self-checking testbench for the identity payload parser.
`timescale 1ns / 100ps

module identity_payload_parser_tb;
  import ipp_pkg::*;

  localparam int unsigned NameMax     = 32;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DirRows     = 32;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  identity_payload_parser #(
    .NAME_MAX(NameMax)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // Labels still owed by the design, oldest first.
  result_t labeled_bytes_due [$];

  // Watchdog: a hung handshake or a lost beat ends here.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d labels still due", cycle_count,
               labeled_bytes_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Rows marked typed carry their label and status by hand;
  // the rest are checked against the parser model below.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0]    data;
    logic          last;
    logic          typed;
    field_kind_t   kind;
    parse_status_t status;
  } dir_row_t;

  dir_row_t dir_rows [DirRows] = '{
    // one byte straight out of reset: too short
    '{8'h00, 1'b1, 1'b1, FK_SLOTS,     ST_TOO_SHORT},
    // smallest complete payload, both names empty, extreme header bytes
    '{8'hFF, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'hFF, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b1, 1'b1, FK_PROD_LEN,  ST_OK},
    // vendor length one past the maximum; the rest trails
    '{8'h01, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h02, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h03, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h21, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h80, 1'b1, 1'b1, FK_TRAIL,     ST_VENDOR_LONG},
    // vendor name ends early
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h02, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h41, 1'b1, 1'b1, FK_VENDOR_CHR, ST_VENDOR_CUT},
    // vendor name complete, product length never arrives
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h01, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h41, 1'b1, 1'b1, FK_VENDOR_CHR, ST_PROD_MISSING},
    // product length at the top of the byte range
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'hFF, 1'b1, 1'b1, FK_PROD_LEN,  ST_PROD_LONG},
    // product name ends early
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h00, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h02, 1'b0, 1'b0, FK_SLOTS,     ST_OK},
    '{8'h7F, 1'b1, 1'b1, FK_PROD_CHR,  ST_PROD_CUT}
  };

  // ---------------------------------------------------------------------------
  // Parser model: phase, position and name counters of the payload in flight.
  // ---------------------------------------------------------------------------
  field_kind_t   cur_field  = FK_SLOTS;
  logic [7:0]    byte_pos   = 8'd0;
  logic [7:0]    name_size  = 8'd0;
  logic [7:0]    name_cnt   = 8'd0;
  parse_status_t first_err  = ST_OK;

  function automatic result_t parse_byte(in_beat_t b);
    result_t r;
    r.field_kind   = FK_TRAIL;
    r.field_value  = b.data_byte;
    r.char_index   = 5'd0;
    r.ends_payload = b.final_byte;
    r.parse_status = ST_OK;
    r.parse_ok     = 1'b0;
    // past the position limit nothing moves but the final flag
    if (byte_pos < PosLimit) begin
      r.field_kind = cur_field;
      case (cur_field)
        FK_SLOTS:  cur_field = FK_VMAJOR;
        FK_VMAJOR: cur_field = FK_VMINOR;
        FK_VMINOR: cur_field = FK_VENDOR_LEN;
        FK_VENDOR_LEN, FK_PROD_LEN: begin
          name_size = b.data_byte;
          name_cnt  = 8'd0;
          if (b.data_byte > NameMax) begin
            // record the first length error, label the rest trailing
            if (cur_field == FK_VENDOR_LEN) first_err = ST_VENDOR_LONG;
            else first_err = ST_PROD_LONG;
            cur_field = FK_TRAIL;
          end else if (b.data_byte == 8'd0) begin
            if (cur_field == FK_VENDOR_LEN) cur_field = FK_PROD_LEN;
            else cur_field = FK_TRAIL;
          end else if (cur_field == FK_VENDOR_LEN) begin
            cur_field = FK_VENDOR_CHR;
          end else begin
            cur_field = FK_PROD_CHR;
          end
        end
        FK_VENDOR_CHR, FK_PROD_CHR: begin
          r.char_index = name_cnt[4:0];
          name_cnt     = name_cnt + 8'd1;
          if (name_cnt >= name_size) begin
            if (cur_field == FK_VENDOR_CHR) cur_field = FK_PROD_LEN;
            else cur_field = FK_TRAIL;
          end
        end
        default: ;
      endcase
      byte_pos = byte_pos + 8'd1;
    end
    if (b.final_byte) begin
      // short payload wins over everything, then length errors, then cuts
      if (byte_pos < MinPayload) r.parse_status = ST_TOO_SHORT;
      else if (first_err != ST_OK) r.parse_status = first_err;
      else if (cur_field == FK_VENDOR_CHR) r.parse_status = ST_VENDOR_CUT;
      else if (cur_field == FK_PROD_LEN) r.parse_status = ST_PROD_MISSING;
      else if (cur_field == FK_PROD_CHR) r.parse_status = ST_PROD_CUT;
      r.parse_ok = (r.parse_status == ST_OK);
      cur_field = FK_SLOTS;
      byte_pos  = 8'd0;
      name_size = 8'd0;
      name_cnt  = 8'd0;
      first_err = ST_OK;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  bit send_quiet = 1'b0;

  // Drive one beat after a random gap, hold until taken, then log its label.
  task automatic send_beat(in_beat_t b, bit typed, result_t typed_res);
    int unsigned gap;
    result_t     want;
    // flip now and then between idling and back-to-back stretches
    if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b.data_byte;
    s_axis_tlast  <= b.final_byte;
    do @(posedge clk); while (!s_axis_tready);
    want = parse_byte(b);
    if (typed) want = typed_res;
    labeled_bytes_due.push_back(want);
  endtask

  in_beat_t    payload_beats [$];
  int unsigned overlong_left = 2;

  // Name length: always in range, with the edges favored.
  function automatic logic [7:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'(NameMax);
    if (r == 2) return 8'(NameMax - 1);
    return 8'($urandom_range(1, NameMax));
  endfunction

  // Build one random payload into payload_beats. Most are well formed with
  // random content; the rest are cut short, carry an oversize length, are
  // plain noise, or run past the position limit.
  task automatic make_payload();
    logic [7:0]  bytes [$];
    logic [7:0]  len;
    int unsigned pick;
    int unsigned keep;
    pick = $urandom_range(0, 99);
    if (pick >= 95 && overlong_left == 0) pick = 0;
    if (pick < 75 || pick >= 95) begin
      repeat (3) bytes.push_back(8'($urandom_range(0, 255)));
      len = pick_length();
      bytes.push_back(len);
      repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
      len = pick_length();
      bytes.push_back(len);
      repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) bytes.push_back(8'($urandom_range(0, 255)));
      if (pick >= 60 && pick < 75) begin
        keep = $urandom_range(1, bytes.size());
        while (bytes.size() > keep) void'(bytes.pop_back());
      end
      if (pick >= 95) begin
        keep = $urandom_range(256, 300);
        while (bytes.size() < keep) bytes.push_back(8'($urandom_range(0, 255)));
        overlong_left--;
      end
    end else if (pick < 85) begin
      repeat (3) bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) begin
        len = 8'($urandom_range(0, 8));
        bytes.push_back(len);
        repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
      end
      bytes.push_back(($urandom_range(0, 1) == 0) ? 8'(NameMax + 1)
                                                   : 8'($urandom_range(NameMax + 1, 255)));
      repeat ($urandom_range(0, 4)) bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 12)) bytes.push_back(8'($urandom_range(0, 255)));
    end
    foreach (bytes[i]) begin
      payload_beats.push_back('{data_byte: bytes[i], final_byte: (i == bytes.size() - 1)});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, compare each beat with the oldest label due.
  // ---------------------------------------------------------------------------
  int unsigned mismatches = 0;
  bit          sink_quiet = 1'b0;

  task automatic report(string what, int unsigned want, int unsigned got);
    if (mismatches < 10) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  task automatic check_result();
    result_t want;
    if (labeled_bytes_due.size() == 0) begin
      report("unexpected output beat, field_value", 0, m_axis_tdata[7:0]);
      return;
    end
    want = labeled_bytes_due.pop_front();
    if (m_axis_tuser != want.field_kind)
      report("field_kind", want.field_kind, m_axis_tuser);
    if (m_axis_tdata[7:0] != want.field_value)
      report("field_value", want.field_value, m_axis_tdata[7:0]);
    if (m_axis_tdata[12:8] != want.char_index)
      report("char_index", want.char_index, m_axis_tdata[12:8]);
    if (m_axis_tdata[15:13] != want.parse_status)
      report("parse_status", want.parse_status, m_axis_tdata[15:13]);
    if (m_axis_tdata[16] != want.parse_ok)
      report("parse_ok", want.parse_ok, m_axis_tdata[16]);
    if (m_axis_tdata[23:17] != 7'd0)
      report("tdata padding", 0, m_axis_tdata[23:17]);
    if (m_axis_tlast != want.ends_payload)
      report("ends_payload", want.ends_payload, m_axis_tlast);
  endtask

  initial begin : sink
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) sink_quiet = !sink_quiet;
      stall = sink_quiet ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random payloads, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_beat_t    beat;
    result_t     typed_res;
    int unsigned items_sent;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      beat.data_byte         = dir_rows[i].data;
      beat.final_byte        = dir_rows[i].last;
      typed_res.field_kind   = dir_rows[i].kind;
      typed_res.field_value  = dir_rows[i].data;
      typed_res.char_index   = 5'd0;
      typed_res.ends_payload = dir_rows[i].last;
      typed_res.parse_status = dir_rows[i].status;
      typed_res.parse_ok     = dir_rows[i].last && (dir_rows[i].status == ST_OK);
      send_beat(beat, dir_rows[i].typed, typed_res);
    end

    items_sent = 0;
    while (items_sent < RandomItems) begin
      make_payload();
      items_sent += payload_beats.size();
      while (payload_beats.size() != 0) send_beat(payload_beats.pop_front(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (labeled_bytes_due.size() != 0) @(posedge clk);
    // hold a little longer to catch any stray beat
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && labeled_bytes_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ipp_pkg.sv
rtl/ipp_in_stage.sv
rtl/ipp_core.sv
rtl/identity_payload_parser.sv
rtl/ipp_checker.sv
sim/identity_payload_parser_tb.sv
